FILE: rtl/ntcu_pkg.sv
// Package: kind codes, transfer payload types and inter-stage records for the cast unit.
package ntcu_pkg;

  typedef enum logic [2:0] {
    KIND_I32 = 3'd0,
    KIND_U32 = 3'd1,
    KIND_I64 = 3'd2,
    KIND_U64 = 3'd3,
    KIND_F32 = 3'd4,
    KIND_PTR = 3'd5
  } kind_e;

  typedef struct packed {
    logic [2:0]  src_kind;
    logic [2:0]  dst_kind;
    logic [63:0] src_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        out_of_range;
    logic        bad_kind;
  } out_item_t;

  // stage 1 -> stage 2: decoded operands
  typedef struct packed {
    logic        bad;
    logic        f2f;       // float32 to float32 pass
    logic        f2i;       // float32 to integer
    logic        i2f;       // integer to float32
    logic        narrow;    // 32-bit integer destination
    logic        is_signed; // signed integer destination
    logic        neg;       // sign of source
    logic [63:0] mag;       // integer magnitude, widened integer, or raw float bits
    logic [7:0]  ex;        // float exponent
    logic [23:0] man;       // float mantissa with hidden bit
    logic        nan;
    logic        inf;
  } s1_t;

  // stage 2 -> stage 3
  typedef struct packed {
    logic        bad;
    logic        f2f;
    logic        f2i;
    logic        i2f;
    logic        narrow;
    logic        is_signed;
    logic        neg;
    logic [63:0] val;       // i2f: normalised magnitude; f2i: shifted magnitude; else raw
    logic [5:0]  lz;        // leading zero count for i2f
    logic        zero;      // i2f magnitude is zero
    logic        nan;
    logic        huge;
  } s2_t;

  // count leading zeros of a 64-bit word (priority scan over the bits)
  function automatic logic [6:0] clz64(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

endpackage

FILE: rtl/ntcu_decode.sv
// Stage 1: kind decode, integer widening and float field split.
module ntcu_decode
  import ntcu_pkg::*;
(
  input  in_item_t in_i,
  output s1_t      dec_o
);

  logic [63:0] w;
  logic        src_signed;
  logic [31:0] f;

  always_comb begin
    f = in_i.src_value[31:0];
    // widen source integer to 64 bits
    case (in_i.src_kind)
      KIND_I32: w = {{32{f[31]}}, f};
      KIND_U32: w = {32'd0, f};
      default:  w = in_i.src_value;
    endcase
    src_signed = (in_i.src_kind == KIND_I32) || (in_i.src_kind == KIND_I64);

    dec_o           = '0;
    dec_o.bad       = (in_i.src_kind > KIND_PTR) || (in_i.dst_kind > KIND_PTR);
    dec_o.f2f       = (in_i.src_kind == KIND_F32) && (in_i.dst_kind == KIND_F32);
    dec_o.f2i       = (in_i.src_kind == KIND_F32) && (in_i.dst_kind != KIND_F32);
    dec_o.i2f       = (in_i.src_kind != KIND_F32) && (in_i.dst_kind == KIND_F32);
    dec_o.narrow    = (in_i.dst_kind == KIND_I32) || (in_i.dst_kind == KIND_U32);
    dec_o.is_signed = (in_i.dst_kind == KIND_I32) || (in_i.dst_kind == KIND_I64);
    dec_o.ex        = f[30:23];
    dec_o.man       = {1'b1, f[22:0]};
    dec_o.nan       = (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    dec_o.inf       = (f[30:23] == 8'hFF);
    if (in_i.src_kind == KIND_F32) begin
      dec_o.neg = f[31];
      dec_o.mag = {32'd0, f};
    end else if (in_i.dst_kind == KIND_F32) begin
      dec_o.neg = src_signed && w[63];
      dec_o.mag = dec_o.neg ? (64'd0 - w) : w;
    end else begin
      dec_o.mag = w;
    end
  end

endmodule

FILE: rtl/ntcu_shift.sv
// Stage 2: normalising shift for int-to-float, alignment shift for float-to-int.
module ntcu_shift
  import ntcu_pkg::*;
(
  input  s1_t s1_i,
  output s2_t s2_o
);

  logic [6:0]  lz;
  logic [63:0] fmag;
  logic        fhuge;

  always_comb begin
    lz    = clz64(s1_i.mag);
    fmag  = '0;
    fhuge = s1_i.inf;
    // float magnitude truncated toward zero
    if (!s1_i.inf && s1_i.ex >= 8'd127) begin
      if (s1_i.ex < 8'd150)
        fmag = {40'd0, s1_i.man} >> (8'd150 - s1_i.ex);
      else if (s1_i.ex - 8'd150 > 8'd40)
        fhuge = 1'b1;
      else
        fmag = {40'd0, s1_i.man} << (s1_i.ex - 8'd150);
    end

    s2_o           = '0;
    s2_o.bad       = s1_i.bad;
    s2_o.f2f       = s1_i.f2f;
    s2_o.f2i       = s1_i.f2i;
    s2_o.i2f       = s1_i.i2f;
    s2_o.narrow    = s1_i.narrow;
    s2_o.is_signed = s1_i.is_signed;
    s2_o.neg       = s1_i.neg;
    s2_o.nan       = s1_i.nan;
    s2_o.huge      = fhuge;
    s2_o.zero      = lz[6];
    s2_o.lz        = lz[5:0];
    if (s1_i.i2f)
      s2_o.val = s1_i.mag << lz[5:0];
    else if (s1_i.f2i)
      s2_o.val = fmag;
    else
      s2_o.val = s1_i.mag;
  end

endmodule

FILE: rtl/ntcu_finish.sv
// Stage 3: rounding and packing for float results, saturation for float-to-integer results.
module ntcu_finish
  import ntcu_pkg::*;
(
  input  s2_t       s2_i,
  output out_item_t res_o
);

  logic [24:0] rnd;
  logic        guard;
  logic        sticky;
  logic [7:0]  expo;
  logic [63:0] pos_lim;
  logic [63:0] neg_lim;
  logic [63:0] m;
  logic [63:0] v;
  logic        sat;

  always_comb begin
    // round to nearest even on the normalised magnitude
    guard  = s2_i.val[39];
    sticky = |s2_i.val[38:0];
    rnd    = {1'b0, s2_i.val[63:40]} +
             25'(guard && (sticky || s2_i.val[40]));
    expo   = 8'(8'd190 - {2'd0, s2_i.lz} + {7'd0, rnd[24]});

    // saturation limits
    if (s2_i.is_signed) begin
      pos_lim = s2_i.narrow ? 64'h7FFF_FFFF : 64'h7FFF_FFFF_FFFF_FFFF;
      neg_lim = pos_lim + 64'd1;
    end else begin
      pos_lim = s2_i.narrow ? 64'hFFFF_FFFF : '1;
      neg_lim = '0;
    end
    m   = s2_i.val;
    sat = 1'b0;
    if (s2_i.neg) begin
      if (s2_i.huge || m > neg_lim) begin
        sat = 1'b1;
        m   = neg_lim;
      end
      v = 64'd0 - m;
    end else begin
      if (s2_i.huge || m > pos_lim) begin
        sat = 1'b1;
        m   = pos_lim;
      end
      v = m;
    end

    res_o = '0;
    if (s2_i.bad) begin
      res_o.bad_kind = 1'b1;
    end else if (s2_i.f2f) begin
      res_o.result_value = {32'd0, s2_i.val[31:0]};
    end else if (s2_i.f2i) begin
      if (s2_i.nan) begin
        res_o.out_of_range = 1'b1;
      end else begin
        res_o.out_of_range = sat;
        res_o.result_value = s2_i.narrow ? {32'd0, v[31:0]} : v;
      end
    end else if (s2_i.i2f) begin
      if (s2_i.zero)
        res_o.result_value = {32'd0, s2_i.neg, 31'd0};
      else
        res_o.result_value = {32'd0, s2_i.neg, expo,
                              rnd[24] ? rnd[23:1] : rnd[22:0]};
    end else begin
      res_o.result_value = s2_i.narrow ? {32'd0, s2_i.val[31:0]} : s2_i.val;
    end
  end

endmodule

FILE: rtl/numeric_type_cast_unit.sv
// Top level: three-stage pipelined numeric cast unit with valid/stall transfers.
//
// Converts a 64-bit raw value between int32, uint32, int64, uint64, float32
// and pointer formats using C cast rules, saturating float-to-integer casts.
// Input channel: in_valid_i / in_stall_o / in_item_i; a transfer happens on a
// clock edge with valid high and stall low. Output channel: out_valid_o /
// out_stall_i / out_item_o, same rule.
// A result passes the decode, shift and round/saturate registers after its input
// transfer. Throughput: one item per cycle while the receiver does not stall.
// Each stage holds its item while the stage after it is full and stalled, so
// a receiver stall fills the pipe and then stalls the sender; no item is lost
// or repeated. Any empty stage lets the stages behind it advance.
// Reset clears all valid bits; payload registers are not reset.
module numeric_type_cast_unit
  import ntcu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  s1_t       s1_d, s1_q;
  s2_t       s2_d, s2_q;
  out_item_t r_d, r_q;
  logic      v1_q, v2_q, v3_q;
  logic      en1, en2, en3;

  ntcu_decode u_dec (.in_i(in_item_i), .dec_o(s1_d));
  ntcu_shift  u_sh  (.s1_i(s1_q), .s2_o(s2_d));
  ntcu_finish u_fin (.s2_i(s2_q), .res_o(r_d));

  // stage advance when the next stage is free
  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_stall_o  = !en1;
  assign out_valid_o = v3_q;
  assign out_item_o  = r_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) r_q  <= r_d;
  end

endmodule

FILE: test/tb_top.sv
// Testbench for the numeric cast unit: directed and random conversions checked against a predictor.
module tb_top;
  import ntcu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CYCLES = 200000;
  localparam logic [2:0] KIND_BAD6 = 3'd6;
  localparam logic [2:0] KIND_BAD7 = 3'd7;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  numeric_type_cast_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  in_item_t  pending_items[$];
  int        n_errors = 0;
  int        n_checked = 0;
  int        n_sent = 0;
  int        cycle_count = 0;
  bit        stim_done = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        stall_phase = 0;

  // float32 to integer with saturation
  function automatic out_item_t float_to_int(logic [2:0] dk, logic [31:0] f);
    out_item_t r;
    logic        neg;
    logic [7:0]  ex;
    logic [63:0] m, mag, pos_lim, neg_lim, v;
    logic        sgn, nar, huge;
    r = '0;
    neg = f[31]; ex = f[30:23];
    m = {40'd0, 1'b1, f[22:0]};
    sgn = (dk == KIND_I32) || (dk == KIND_I64);
    nar = (dk == KIND_I32) || (dk == KIND_U32);
    huge = 1'b0; mag = '0;
    if (ex == 8'hFF && f[22:0] != 0) begin
      r.out_of_range = 1'b1;
      return r;
    end
    if (ex == 8'hFF) huge = 1'b1;
    else if (ex >= 8'd127) begin
      if (ex < 8'd150) mag = m >> (150 - ex);
      else if (ex - 150 > 40) huge = 1'b1;
      else mag = m << (ex - 150);
    end
    if (sgn) begin
      pos_lim = nar ? 64'h7FFF_FFFF : 64'h7FFF_FFFF_FFFF_FFFF;
      neg_lim = pos_lim + 1;
    end else begin
      pos_lim = nar ? 64'hFFFF_FFFF : '1;
      neg_lim = '0;
    end
    if (neg) begin
      if (huge || mag > neg_lim) begin
        r.out_of_range = 1'b1; mag = neg_lim;
      end
      v = -mag;
    end else begin
      if (huge || mag > pos_lim) begin
        r.out_of_range = 1'b1; mag = pos_lim;
      end
      v = mag;
    end
    r.result_value = nar ? {32'd0, v[31:0]} : v;
    return r;
  endfunction

  // sign and magnitude to float32, round to nearest even
  function automatic logic [63:0] int_to_float(logic neg, logic [63:0] mag);
    int          p, s;
    logic [63:0] mant, rem, half;
    logic [31:0] b;
    if (mag == 0) return neg ? 64'h8000_0000 : 64'd0;
    p = 63;
    while (!mag[p]) p--;
    if (p <= 23) mant = mag << (23 - p);
    else begin
      s = p - 23;
      rem = mag & ((64'd1 << s) - 1);
      half = 64'd1 << (s - 1);
      mant = mag >> s;
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant == (64'd1 << 24)) begin
        mant >>= 1; p++;
      end
    end
    b = {neg, 8'(p + 127), mant[22:0]};
    return {32'd0, b};
  endfunction

  function automatic out_item_t predict_cast(in_item_t it);
    out_item_t   r;
    logic [63:0] w;
    logic        neg;
    r = '0;
    if (it.src_kind > KIND_PTR || it.dst_kind > KIND_PTR) begin
      r.bad_kind = 1'b1;
      return r;
    end
    if (it.src_kind == KIND_F32) begin
      if (it.dst_kind == KIND_F32) r.result_value = {32'd0, it.src_value[31:0]};
      else r = float_to_int(it.dst_kind, it.src_value[31:0]);
      return r;
    end
    case (it.src_kind)
      KIND_I32: w = {{32{it.src_value[31]}}, it.src_value[31:0]};
      KIND_U32: w = {32'd0, it.src_value[31:0]};
      default:  w = it.src_value;
    endcase
    if (it.dst_kind == KIND_F32) begin
      neg = (it.src_kind == KIND_I32 || it.src_kind == KIND_I64) && w[63];
      r.result_value = int_to_float(neg, neg ? -w : w);
    end else if (it.dst_kind == KIND_I32 || it.dst_kind == KIND_U32)
      r.result_value = {32'd0, w[31:0]};
    else
      r.result_value = w;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // interesting float32 patterns
  function automatic logic [31:0] rand_float();
    logic [31:0] f;
    f = $urandom();
    case ($urandom_range(0, 5))
      0: f[30:23] = 8'd255;
      1: f[30:23] = 8'($urandom_range(120, 200));
      2: f[30:23] = 8'($urandom_range(155, 192));
      3: f[30:23] = 8'($urandom_range(0, 2));
      default: ;
    endcase
    return f;
  endfunction

  function automatic logic [63:0] rand_int_value();
    logic [63:0] v;
    v = rand64();
    case ($urandom_range(0, 4))
      0: v = v >> $urandom_range(0, 63);
      1: v = ~(v >> $urandom_range(0, 63));
      2: v = 64'd1 << $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_item(logic [2:0] sk, logic [2:0] dk, logic [63:0] v);
    in_item_t it;
    it.src_kind = sk; it.dst_kind = dk; it.src_value = v;
    pending_items.push_back(it);
  endtask

  // stimulus
  initial begin
    logic [2:0] sk, dk;
    // directed corners
    add_item(KIND_I32, KIND_I64, 64'hFFFF_FFFF_8000_0000);
    add_item(KIND_U32, KIND_I64, 64'hFFFF_FFFF_FFFF_FFFF);
    add_item(KIND_I64, KIND_I32, 64'h1234_5678_9ABC_DEF0);
    add_item(KIND_U64, KIND_F32, 64'hFFFF_FFFF_FFFF_FFFF);
    add_item(KIND_I64, KIND_F32, 64'h8000_0000_0000_0000);
    add_item(KIND_I32, KIND_F32, 64'h0100_0001);
    add_item(KIND_I32, KIND_F32, 64'h0100_0003);
    add_item(KIND_PTR, KIND_F32, 64'd0);
    add_item(KIND_F32, KIND_I32, 64'h7FC0_0000);
    add_item(KIND_F32, KIND_U64, 64'h7F80_0000);
    add_item(KIND_F32, KIND_I64, 64'hFF80_0000);
    add_item(KIND_F32, KIND_U32, 64'hBF00_0000);
    add_item(KIND_F32, KIND_PTR, 64'hC000_0000);
    add_item(KIND_F32, KIND_I32, 64'h4F00_0000);
    add_item(KIND_F32, KIND_I32, 64'hCF00_0000);
    add_item(KIND_F32, KIND_U32, 64'h0000_0001);
    add_item(KIND_F32, KIND_F32, 64'hFFFF_FFFF_7FC0_0001);
    add_item(KIND_F32, KIND_U64, 64'h5F7F_FFFF);
    add_item(KIND_F32, KIND_I64, 64'hDF00_0000);
    add_item(KIND_BAD6, KIND_I32, 64'hFFFF_FFFF_FFFF_FFFF);
    add_item(KIND_I32, KIND_BAD7, 64'd5);
    add_item(KIND_PTR, KIND_U32, 64'hFFFF_FFFF_FFFF_FFFF);
    // random part, mostly valid kinds
    repeat (1900) begin
      sk = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
      dk = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
      if (sk == KIND_F32) add_item(sk, dk, {$urandom(), rand_float()});
      else add_item(sk, dk, rand_int_value());
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    stim_done = 1'b1;
  end

  // driver: bursts with random gaps
  always @(posedge clk_i) begin
    if (rst_ni && stim_done) begin
      if (!(in_valid_i && in_stall_o)) begin
        if (in_valid_i) n_sent++;
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item_i <= pending_items.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
          end
        end else
          in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall pattern: phases of none, light and heavy stalling
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cycle_count % 300 == 0) stall_phase = $urandom_range(0, 2);
      case (stall_phase)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // monitor: check each accepted result against the oldest expectation
  in_item_t sent_items[$];
  always @(posedge clk_i) begin
    out_item_t exp_r;
    cycle_count++;
    if (rst_ni && in_valid_i && !in_stall_o) sent_items.push_back(in_item_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sent_items.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %h", out_item_o);
      end else begin
        exp_r = predict_cast(sent_items.pop_front());
        n_checked++;
        if (exp_r !== out_item_o) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: value exp %h got %h, range exp %b got %b, bad exp %b got %b",
                     exp_r.result_value, out_item_o.result_value, exp_r.out_of_range,
                     out_item_o.out_of_range, exp_r.bad_kind, out_item_o.bad_kind);
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while ((pending_items.size() > 0 || in_valid_i || sent_items.size() > 0)
           && cycle_count < MAX_CYCLES)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (cycle_count >= MAX_CYCLES) begin
      $display("FAIL");
    end else begin
      $display("Sent %0d and checked %0d conversions across kind pairs, float corners, bad kinds,",
               n_sent, n_checked);
      $display("with random sender gaps and receiver stalls; %0d errors.", n_errors);
      if (n_errors == 0 && sent_items.size() == 0) begin
        $display("PASS");
      end else begin
        $display("FAIL");
      end
    end
    $finish;
  end
endmodule
